>>> rtl/console_line_editor_macros.svh
// ----------------------------------------------------------------------------
// Console line editor assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

`ifndef ASSERT_OFF

// ante true at an edge implies cons at the same edge
`define CLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante true at an edge implies cons at the next edge
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLE_ASSERT_IMP(lbl, ante, cons, msg)
`define CLE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_KILL      = 8'h15;
  localparam logic [7:0] CH_EOF       = 8'h04;

  typedef struct packed {
    logic [7:0] char_code;
    logic       more_pending;
  } cle_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_line;
    logic       empty_line;
  } cle_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // input word accepted this cycle
    logic issue_byte;  // load next stored byte into the output register
    logic issue_mark;  // load the end-of-input marker into the output register
  } cle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go;          // accepted word sends the line
    logic go_empty;    // and the line is empty
    logic out_free;    // output register can take a word this cycle
    logic last_byte;   // read index is at the final stored byte
  } cle_sts_t;

endpackage

>>> rtl/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical line discipline: edits keyboard bytes into lines and streams
// each finished line out one byte per word.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_ready   | cle_in_t (char_code, more_pending)
//   out_    | output    | out_valid/out_ready | cle_out_t (data_byte, last, empty)
//   cfg_    | input     | cfg_we              | raw_mode bit
//
// A word that sends a line of n bytes moves the controller to STREAM: the
// line store has one read port, so one byte a cycle leaves it while the
// output register is free; an empty send moves it to MARK for the end-of-input
// marker. in_ready is low while a line streams, and out_ready low stalls the
// stream with the word held. Synchronous active-low reset clears the fill
// count, read index, mode and output valid; the line store needs no clearing.
// ----------------------------------------------------------------------------
module console_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  cle_pkg::cle_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cle_pkg::cle_out_t out_data
);

  import cle_pkg::*;

  cle_cmd_t cmd;
  cle_sts_t sts;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Byte decode, fill count, line store and output register of the editor.
// ----------------------------------------------------------------------------
module cle_datapath #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  cle_pkg::cle_in_t  in_data,
  input  logic              out_ready,
  input  cle_pkg::cle_cmd_t cmd,
  output cle_pkg::cle_sts_t sts,
  output logic              out_valid,
  output cle_pkg::cle_out_t out_data
);

  import cle_pkg::*;

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_DEPTH);

  logic             raw_mode_r;
  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_r, last_nxt;
  logic             empty_r, empty_nxt;

  logic             store_en;
  logic             send;
  logic [CNT_W-1:0] fill_after;
  logic [7:0]       rdata;

  // decode one input word against the current fill count
  always_comb begin
    store_en   = 1'b0;
    send       = 1'b0;
    fill_after = fill_count_r;
    if (in_data.char_code == CH_NUL) begin
      send = (fill_count_r != '0) && !in_data.more_pending;
    end else if (raw_mode_r) begin
      store_en = 1'b1;
      send     = !in_data.more_pending;
    end else begin
      unique case (in_data.char_code)
        CH_BACKSPACE: begin
          if (fill_count_r != '0) fill_after = fill_count_r - CNT_W'(1);
        end
        CH_KILL:      fill_after = '0;
        CH_EOF:       send = 1'b1;
        CH_NEWLINE: begin
          store_en = 1'b1;
          send     = 1'b1;
        end
        default:      store_en = 1'b1;
      endcase
    end
    if (store_en && fill_count_r < FULL) begin
      fill_after = fill_count_r + CNT_W'(1);
    end else begin
      store_en = 1'b0;
    end
  end

  assign sts.go        = send || (fill_after == FULL);
  assign sts.go_empty  = (fill_after == '0);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.last_byte = (CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_count_r;

  always_comb begin
    fill_count_nxt = fill_count_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r;
    last_nxt       = last_r;
    empty_nxt      = empty_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.take) fill_count_nxt = fill_after;
    if (cmd.issue_byte) begin
      out_valid_nxt = 1'b1;
      last_nxt      = sts.last_byte;
      empty_nxt     = 1'b0;
      if (sts.last_byte) begin
        rd_idx_nxt     = '0;
        fill_count_nxt = '0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end
    if (cmd.issue_mark) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      empty_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r   <= 1'b0;
      fill_count_r <= '0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) raw_mode_r <= cfg_wdata;
      fill_count_r <= fill_count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.take && store_en),
    .waddr (fill_count_r[IDX_W-1:0]),
    .wdata (in_data.char_code),
    .re    (cmd.issue_byte),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  assign out_valid              = out_valid_r;
  assign out_data.data_byte     = empty_r ? 8'h00 : rdata;
  assign out_data.last_of_line  = last_r;
  assign out_data.empty_line    = empty_r;

`include "console_line_editor_macros.svh"

  `CLE_ASSERT_IMP(a_take_not_full, cmd.take, fill_count_r < FULL, "take with full store")
  `CLE_ASSERT_IMP(a_byte_nonempty, cmd.issue_byte, fill_count_r != '0, "byte from empty store")
  `CLE_ASSERT_IMP(a_mark_empty, cmd.issue_mark, fill_count_r == '0, "marker with stored bytes")

endmodule

>>> rtl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller: accepts input words and sequences the sending of a line.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cle_pkg::cle_sts_t sts,
  output cle_pkg::cle_cmd_t cmd
);

  import cle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_MARK
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready       = (state_r == ST_IDLE);
  assign cmd.take       = in_valid && in_ready;
  assign cmd.issue_byte = (state_r == ST_STREAM) && sts.out_free;
  assign cmd.issue_mark = (state_r == ST_MARK) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && sts.go) state_nxt = sts.go_empty ? ST_MARK : ST_STREAM;
      end
      ST_STREAM: begin
        if (cmd.issue_byte && sts.last_byte) state_nxt = ST_IDLE;
      end
      ST_MARK: begin
        if (cmd.issue_mark) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "console_line_editor_macros.svh"

  `CLE_ASSERT_IMP(a_one_issue, 1'b1, $onehot0({cmd.issue_byte, cmd.issue_mark}), "double issue")
  `CLE_ASSERT_IMP(a_no_take_busy, cmd.take, !cmd.issue_byte && !cmd.issue_mark, "take while busy")
  `CLE_ASSERT_NXT(a_end_ready, cmd.issue_byte && sts.last_byte, in_ready, "not ready after line")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console line editor testbench
// Drives keystroke words through the valid/ready input channel and predicts
// every line word that should leave the output channel. A line model tracks
// the edit buffer and raw mode and queues the expected words. A checker
// compares each accepted output word field by field. Both sides idle at
// random, and one long receiver hold-off backs the editor up into its input.
// ----------------------------------------------------------------------------
module tb;
  import cle_pkg::*;

  localparam int DEPTH          = LINE_DEPTH_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 30;
  localparam int PHASE_WORDS    = 10;
  localparam int MAX_REPORTS    = 30;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  cle_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cle_out_t out_data;

  // line model: edit buffer, mode and the predicted words not yet checked
  logic [7:0] edit_buf[$];
  logic       raw_on = 1'b0;
  cle_out_t   line_words_q[$];

  int   errors       = 0;
  int   words_in     = 0;
  logic idle_on      = 1'b1;
  int   hold_req     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   stall_left   = 0;
  int   quiet_cycles = 0;

  console_line_editor #(
    .LINE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Edit the line with one keystroke and queue whatever line it sends.
  task automatic apply_keystroke(input cle_in_t w);
    logic     send;
    cle_out_t o;
    send = 1'b0;
    if (w.char_code == CH_NUL) begin
      if (edit_buf.size() > 0) send = !w.more_pending;
    end else if (raw_on) begin
      if (edit_buf.size() < DEPTH) edit_buf.push_back(w.char_code);
      send = !w.more_pending;
    end else if (w.char_code == CH_BACKSPACE) begin
      if (edit_buf.size() > 0) void'(edit_buf.pop_back());
    end else if (w.char_code == CH_KILL) begin
      edit_buf.delete();
    end else if (w.char_code == CH_EOF) begin
      send = 1'b1;
    end else begin
      if (edit_buf.size() < DEPTH) edit_buf.push_back(w.char_code);
      if (w.char_code == CH_NEWLINE) send = 1'b1;
    end
    if (send || edit_buf.size() >= DEPTH) begin
      if (edit_buf.size() == 0) begin
        o.data_byte    = 8'h00;
        o.last_of_line = 1'b1;
        o.empty_line   = 1'b1;
        line_words_q.push_back(o);
      end else begin
        foreach (edit_buf[i]) begin
          o.data_byte    = edit_buf[i];
          o.last_of_line = (i == edit_buf.size() - 1);
          o.empty_line   = 1'b0;
          line_words_q.push_back(o);
        end
        edit_buf.delete();
      end
    end
  endtask

  // Offer one keystroke; hold it until accepted, then predict.
  task automatic send_key(input logic [7:0] ch, input logic more);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {ch, more};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_keystroke(in_data);
    words_in++;
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_key(s[i], 1'($urandom_range(0, 1)));
  endtask

  // Printable or high byte: never an editing code in cooked mode.
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Drop valid and wait until every predicted word has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (line_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_raw(input logic v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    raw_on = v;
  endtask

  // receiver: per-word stall, plus a long hold-off on request
  always @(posedge clk) begin : rx_side
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      stall_left <= stall;
      out_ready  <= (stall == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : line_check
    cle_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_words_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got %02h last=%b empty=%b",
                   $time, out_data.data_byte, out_data.last_of_line, out_data.empty_line);
      end else begin
        want = line_words_q.pop_front();
        check_field("data_byte", want.data_byte, out_data.data_byte);
        check_field("last_of_line", 8'(want.last_of_line), 8'(out_data.last_of_line));
        check_field("empty_line", 8'(want.empty_line), 8'(out_data.empty_line));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_cooked_edits();
    set_raw(1'b0);
    send_str("ab");
    send_key(CH_BACKSPACE, 1'b1);
    send_str("c");
    send_key(CH_NEWLINE, 1'b0);
    send_key(CH_BACKSPACE, 1'b0);  // backspace on an empty line
    send_key(CH_KILL, 1'b1);       // kill on an empty line
    send_key(CH_EOF, 1'b0);        // empty send: end-of-input marker
    send_str("xy");
    send_key(CH_KILL, 1'b0);
    send_key(8'hFF, 1'b1);
    send_key(8'h01, 1'b0);
    send_key(CH_EOF, 1'b1);
    send_key(CH_NUL, 1'b0);        // flush with nothing held
    send_key(8'h80, 1'b0);
    send_key(CH_NUL, 1'b1);        // flush while more input waits
    send_key(CH_NUL, 1'b0);
    send_key(8'h7F, 1'b1);
    send_key(CH_NEWLINE, 1'b1);
  endtask

  task automatic test_raw_mode();
    set_raw(1'b1);
    // editing codes are plain data here
    send_key(CH_BACKSPACE, 1'b1);
    send_key(CH_KILL, 1'b1);
    send_key(CH_EOF, 1'b1);
    send_key(CH_NEWLINE, 1'b1);
    send_key(CH_NUL, 1'b1);
    send_key(8'hFF, 1'b0);
    send_key(CH_NUL, 1'b0);
    send_key(8'h41, 1'b1);
    send_key(CH_NUL, 1'b0);
    send_key(8'h01, 1'b0);
  endtask

  task automatic test_full_store();
    set_raw(1'b0);
    repeat (DEPTH) send_key(text_byte(), 1'($urandom_range(0, 1)));
    set_raw(1'b1);
    repeat (DEPTH) send_key(8'($urandom_range(1, 255)), 1'b1);
  endtask

  task automatic test_hold_off();
    set_raw(1'b0);
    idle_on  <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (3) begin
      repeat ($urandom_range(3, 12)) send_key(text_byte(), 1'b1);
      send_key(CH_NEWLINE, 1'b0);
    end
    idle_on <= 1'b1;
  endtask

  task automatic test_random();
    int phase;
    int stop;
    int n;
    int k;
    int target;
    target = words_in + RANDOM_WORDS;
    for (phase = 0; words_in < target; phase++) begin
      set_raw(phase % 3 == 1);
      idle_on <= (phase % 4 != 3);
      stop = words_in + PHASE_WORDS;
      while (words_in < stop) begin
        if ($urandom_range(0, 9) >= 7) begin
          send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (raw_on) begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) send_key(8'($urandom_range(1, 255)), k != n - 1);
          if ($urandom_range(0, 3) == 0) send_key(CH_NUL, 1'b0);
        end else begin
          n = $urandom_range(0, 12);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
              0: send_key(CH_BACKSPACE, 1'($urandom_range(0, 1)));
              1: send_key(($urandom_range(0, 2) == 0) ? CH_KILL : text_byte(), 1'b1);
              default: send_key(text_byte(), 1'($urandom_range(0, 1)));
            endcase
          end
          send_key(($urandom_range(0, 3) == 0) ? CH_EOF : CH_NEWLINE,
                   1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cooked_edits();
    test_raw_mode();
    test_full_store();
    test_hold_off();
    test_random();
    wait_idle();
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_datapath.sv
rtl/cle_ctrl.sv
rtl/console_line_editor.sv
dv/tb.sv
